>>> sv/cts_pkg.sv
`default_nettype none

package cts_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	// field widths
	localparam int KEY_W   = 32;
	localparam int CHAR_W  = 21;
	localparam int RAND_W  = 32;
	localparam int SCALE_W = 48;
	localparam int TENT_W  = 9;

	// input op codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// result status codes
	localparam logic STAT_FOUND    = 1'b0;
	localparam logic STAT_NOTFOUND = 1'b1;

	// one table entry as stored in the memory
	typedef struct packed {
		logic [CHAR_W-1:0] chr;
		logic [KEY_W-1:0]  key;
	} cts_entry_t;

	// request from the sequencer to the table memory
	typedef struct packed {
		logic             we;
		logic             re;
		logic [IDX_W-1:0] addr;
		cts_entry_t       wdata;
	} cts_mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_RD,
		ST_CMP,
		ST_DONE
	} cts_state_t;

endpackage

`default_nettype wire

>>> sv/cts_table_mem.sv
`default_nettype none

module cts_table_mem (
	input  wire logic                  clk,
	input  wire cts_pkg::cts_mem_req_t req,
	output cts_pkg::cts_entry_t        rdata
);
	import cts_pkg::*;

	// threshold and character side by side, one entry per position
	cts_entry_t mem [TABLE_DEPTH];
	cts_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/cts_scale_unit.sv
`default_nettype none

module cts_scale_unit (
	input  wire logic                           clk,
	input  wire logic [cts_pkg::RAND_W-1:0]     random_word,
	input  wire logic [cts_pkg::SCALE_W-1:0]    scale,
	output logic      [cts_pkg::KEY_W-1:0]      value
);
	import cts_pkg::*;

	logic [63:0] p_lo_s1;
	logic [47:0] p_hi_s1;
	logic [31:0] value_s2;
	logic [48:0] whole;

	// stage 1: low 32 and high 16 bits of the factor, separate products
	always_ff @(posedge clk) begin
		p_lo_s1 <= 64'(random_word) * 64'(scale[31:0]);
		p_hi_s1 <= 48'(random_word) * 48'(scale[47:32]);
	end

	// stage 2: add 1.5 and truncate; the fraction carry is 1, or 2 when
	// the low product fraction is at least one half
	assign whole = 49'(p_hi_s1) + 49'(p_lo_s1[63:32]) + 49'(1) + 49'(p_lo_s1[31]);

	always_ff @(posedge clk) begin
		value_s2 <= (|whole[48:32]) ? '1 : whole[31:0];
	end

	assign value = value_s2;

endmodule

`default_nettype wire

>>> sv/cts_seq.sv
`default_nettype none

module cts_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input item
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic                          op,
	input  wire logic [7:0]                    entry_index,
	input  wire logic [cts_pkg::KEY_W-1:0]     entry_key,
	input  wire logic [cts_pkg::CHAR_W-1:0]    entry_char,
	input  wire logic [cts_pkg::RAND_W-1:0]    random_word,
	input  wire logic                          last_draw,
	// configuration and scaled value
	input  wire logic [cts_pkg::TENT_W-1:0]    table_entries,
	output logic      [cts_pkg::RAND_W-1:0]    rand_word,
	input  wire logic [cts_pkg::KEY_W-1:0]     value,
	// table memory
	output cts_pkg::cts_mem_req_t              mem_req,
	input  wire cts_pkg::cts_entry_t           mem_rdata,
	// result
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [cts_pkg::CHAR_W-1:0]    char_out,
	output logic                               status,
	output logic                               last
);
	import cts_pkg::*;

	cts_state_t state_q, state_d;

	logic [RAND_W-1:0] rand_q;
	logic              last_draw_q;
	logic [CNT_W-1:0]  lo_q, hi_q, n_q;
	logic [IDX_W-1:0]  mid_q;
	logic [CHAR_W-1:0] chr_q;
	logic              m_tvalid_q;
	logic [CHAR_W-1:0] char_out_q;
	logic              status_q;
	logic              last_q;

	logic              in_acc;
	logic              out_free;
	logic [CNT_W:0]    mid_sum;
	logic [IDX_W-1:0]  mid;
	logic [CNT_W-1:0]  n_eff;

	assign in_acc   = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;
	assign mid_sum  = (CNT_W+1)'(lo_q) + (CNT_W+1)'(hi_q);
	assign mid      = mid_sum[IDX_W:1];
	assign n_eff    = (32'(table_entries) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
	                                                      : CNT_W'(table_entries);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && op == OP_DRAW) state_d = ST_MUL;
			end
			ST_MUL:  state_d = ST_ADD;
			ST_ADD:  state_d = ST_RD;
			ST_RD: begin
				state_d = (lo_q < hi_q) ? ST_CMP : ST_DONE;
			end
			ST_CMP:  state_d = ST_RD;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer; loads write only in idle, so a read never
	// meets a write to the same entry
	always_comb begin
		s_tready      = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.addr  = mid;
		mem_req.wdata = '{chr: entry_char, key: entry_key};
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				mem_req.we = in_acc && op == OP_LOAD && 32'(entry_index) < TABLE_DEPTH;
				mem_req.addr = IDX_W'(entry_index);
			end
			ST_RD: begin
				mem_req.re = lo_q < hi_q;
			end
			ST_MUL, ST_ADD, ST_CMP, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// draw capture, search bounds and result payload
	always_ff @(posedge clk) begin
		if (in_acc && op == OP_DRAW) begin
			rand_q      <= random_word;
			last_draw_q <= last_draw;
		end
		if (state_q == ST_ADD) begin
			lo_q <= '0;
			hi_q <= n_eff;
			n_q  <= n_eff;
			chr_q <= '0;
		end
		if (state_q == ST_RD) begin
			mid_q <= mid;
		end
		// threshold below value: go right; else this entry is the best so far
		if (state_q == ST_CMP) begin
			if (mem_rdata.key < value) begin
				lo_q <= CNT_W'(mid_q) + CNT_W'(1);
			end else begin
				hi_q  <= CNT_W'(mid_q);
				chr_q <= mem_rdata.chr;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			char_out_q <= (hi_q < n_q) ? chr_q : '0;
			status_q   <= (hi_q < n_q) ? STAT_FOUND : STAT_NOTFOUND;
			last_q     <= last_draw_q;
		end
	end

	assign rand_word = rand_q;
	assign m_tvalid  = m_tvalid_q;
	assign char_out  = char_out_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

`default_nettype wire

>>> sv/cdf_table_sampler_top.sv
// Channel   Dir  Handshake          Content
// s_*       in   s_tvalid/s_tready  load entry or draw request (tuser = op)
// m_*       out  m_tvalid/m_tready  drawn character (tuser = status)
// APB       in   psel/penable       scale at 0x0, table_entries at 0x8
//
// A load returns nothing. A draw first scales its random word in the
// multiplier (states MUL and ADD), then runs k = ceil(log2(n+1)) search
// steps for n searched entries, each a RD state that issues one
// registered read of the table memory and a CMP state that uses it.
// Reset clears control state only; the table is valid only where loaded.
// A finished result waits in the output register; the next request is
// taken while it waits, and a draw stalls only at its end if it is still
// there.
`default_nettype none

module cdf_table_sampler_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] entry_index, [39:8] entry_key, [60:40] entry_char,
	// [92:61] random_word, [95:93] zero
	input  wire logic [95:0] s_tdata,
	input  wire logic        s_tuser,   // [0] op
	input  wire logic        s_tlast,   // last_draw
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // [20:0] char_out, [23:21] zero
	output logic             m_tuser,   // [0] status
	output logic             m_tlast,   // last
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);
	import cts_pkg::*;

	logic [SCALE_W-1:0] scale_q;
	logic [TENT_W-1:0]  table_entries_q;
	logic               cfg_wr;
	logic [RAND_W-1:0]  rand_word;
	logic [KEY_W-1:0]   value;
	logic [CHAR_W-1:0]  char_out;
	cts_mem_req_t       mem_req;
	cts_entry_t         mem_rdata;

	// configuration registers, selected by address bit 3
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q         <= SCALE_W'(64'h1_0000_0000);
			table_entries_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[3]) begin
				table_entries_q <= pwdata[TENT_W-1:0];
			end else begin
				scale_q <= pwdata[SCALE_W-1:0];
			end
		end
	end

	assign prdata = paddr[3] ? 64'(table_entries_q) : 64'(scale_q);

	cts_scale_unit u_scale (
		.clk         (clk),
		.random_word (rand_word),
		.scale       (scale_q),
		.value       (value)
	);

	cts_table_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	cts_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.op            (s_tuser),
		.entry_index   (s_tdata[7:0]),
		.entry_key     (s_tdata[39:8]),
		.entry_char    (s_tdata[60:40]),
		.random_word   (s_tdata[92:61]),
		.last_draw     (s_tlast),
		.table_entries (table_entries_q),
		.rand_word     (rand_word),
		.value         (value),
		.mem_req       (mem_req),
		.mem_rdata     (mem_rdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.char_out      (char_out),
		.status        (m_tuser),
		.last          (m_tlast)
	);

	assign m_tdata = {3'b000, char_out};

endmodule

`default_nettype wire

>>> sv/cts_checker.sv
`default_nettype none

module cts_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic        s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        m_tlast,
	input  wire logic        pready
);
	import cts_pkg::*;

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// a not-found result carries character zero
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_NOTFOUND |-> m_tdata == 24'd0)
		else $error("not-found result with nonzero character");

	// a draw occupies the block: no request taken in the next cycles
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_DRAW |=> !s_tready ##1 !s_tready)
		else $error("request taken during a draw");

	// a load never brings a result in the next cycle from an idle block
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_LOAD && !m_tvalid |=> !m_tvalid)
		else $error("result after load");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind cdf_table_sampler_top cts_checker u_cts_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
	import cts_pkg::*;

	localparam logic [3:0]         ADDR_SCALE    = 4'h0;
	localparam logic [3:0]         ADDR_ENTRIES  = 4'h8;
	localparam logic [SCALE_W-1:0] SCALE_ONE     = 48'h1_0000_0000;
	localparam logic [SCALE_W-1:0] SCALE_MAX     = 48'hFFFF_FFFF_FFFF;
	localparam logic [TENT_W-1:0]  ENTRIES_MAX   = 9'd511;
	localparam int                 SETTLE_CYCLES = 30;
	localparam int                 IDLE_LIMIT    = 2000;
	localparam int                 LONG_HOLD     = 300;
	localparam int                 HOLD_AT       = 40;
	localparam int                 RANDOM_ITEMS  = 500;
	localparam int                 MAX_REPORTS   = 10;

	typedef struct {
		logic [CHAR_W-1:0] chr;
		logic              stat;
		logic              lst;
	} drawn_char_t;

	// mirror of the sampler: table contents, registers and the drawn characters still due
	class draw_scoreboard;
		logic [SCALE_W-1:0] scale;
		logic [TENT_W-1:0]  entries;
		logic [KEY_W-1:0]   thresholds[TABLE_DEPTH];
		logic [CHAR_W-1:0]  chars[TABLE_DEPTH];
		drawn_char_t        due_chars[$];
		int                 errors;

		function new();
			scale   = SCALE_ONE;
			entries = '0;
			errors  = 0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				thresholds[i] = '0;
				chars[i]      = '0;
			end
		endfunction

		function void flag_error(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("mismatch at %0t: %s", $time, msg);
		endfunction

		// an accepted request: a load updates the table, a draw predicts its character
		function void note_request(logic op, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key,
			logic [CHAR_W-1:0] chr, logic [RAND_W-1:0] rw, logic lst);
			logic [80:0]      prod;
			logic [80:0]      wide_rw;
			logic [80:0]      wide_scale;
			logic [KEY_W-1:0] target;
			drawn_char_t      res;
			int               n;
			int               lo;
			int               hi;
			int               mid;
			if (op == OP_LOAD) begin
				thresholds[idx] = key;
				chars[idx]      = chr;
			end else begin
				// rw * scale + 1.5 in Q.32, truncated, saturated to 32 bits
				wide_rw    = 81'(rw);
				wide_scale = 81'(scale);
				prod       = wide_rw * wide_scale + 81'h1_8000_0000;
				target     = (prod[80:64] != '0) ? 32'hFFFF_FFFF : prod[63:32];
				// lower-bound search over the active entries
				n = int'(entries);
				if (n > TABLE_DEPTH)
					n = TABLE_DEPTH;
				lo = 0;
				hi = n;
				while (lo < hi) begin
					mid = (lo + hi) / 2;
					if (thresholds[mid] < target)
						lo = mid + 1;
					else
						hi = mid;
				end
				if (lo < n) begin
					res.chr  = chars[lo];
					res.stat = STAT_FOUND;
				end else begin
					res.chr  = '0;
					res.stat = STAT_NOTFOUND;
				end
				res.lst = lst;
				due_chars.push_back(res);
			end
		endfunction

		function void check_result(logic [CHAR_W-1:0] chr, logic stat, logic lst);
			drawn_char_t want;
			if (due_chars.size() == 0) begin
				flag_error($sformatf("char %h status %b last %b with none due", chr, stat, lst));
			end else begin
				want = due_chars.pop_front();
				if (want.chr !== chr || want.stat !== stat || want.lst !== lst)
					flag_error($sformatf("expected char %h status %b last %b, got %h %b %b",
						want.chr, want.stat, want.lst, chr, stat, lst));
			end
		endfunction

		function void check_leftover();
			if (due_chars.size() != 0)
				flag_error($sformatf("%0d drawn characters never arrived", due_chars.size()));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	draw_scoreboard sb;
	bit             loaded[TABLE_DEPTH];
	bit             send_steady = 1'b0;
	bit             recv_steady = 1'b0;
	int             items_sent = 0;
	int             results_seen = 0;
	int             idle_cycles = 0;

	cdf_table_sampler_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// offer one request after a random gap and hold it until taken
	task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
		input logic [KEY_W-1:0] key, input logic [CHAR_W-1:0] chr,
		input logic [RAND_W-1:0] rw, input logic lst);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 3);
		if ($urandom_range(0, 39) == 0)
			send_steady = !send_steady;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tlast  <= lst;
		s_tdata  <= {3'b000, rw, chr, key, idx};
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, idx, key, chr, rw, lst);
		items_sent++;
	endtask

	task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] key,
		input logic [CHAR_W-1:0] chr);
		send_request(OP_LOAD, idx, key, chr, $urandom(), 1'($urandom_range(0, 1)));
		loaded[idx] = 1'b1;
	endtask

	// entry fields of a draw are noise
	task automatic draw_char(input logic [RAND_W-1:0] rw, input logic lst);
		send_request(OP_DRAW, IDX_W'($urandom()), $urandom(), CHAR_W'($urandom()), rw, lst);
	endtask

	// stop offering, wait for every drawn character, then let a trailing load finish
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.due_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [SCALE_W-1:0] scl, input logic [TENT_W-1:0] n);
		write_reg(ADDR_SCALE, {16'h0, scl});
		sb.scale = scl;
		write_reg(ADDR_ENTRIES, {55'h0, n});
		sb.entries = n;
	endtask

	// result side: random hold-off per result, one long hold-off while requests are
	// still offered, to back the block up
	initial begin
		int hold;
		bit long_done;
		hold      = 0;
		long_done = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata[CHAR_W-1:0], m_tuser, m_tlast);
				results_seen++;
				if (!long_done && results_seen >= HOLD_AT && s_tvalid) begin
					hold      = LONG_HOLD;
					long_done = 1'b1;
				end else begin
					hold = recv_steady ? 0 : $urandom_range(0, 3);
					if ($urandom_range(0, 29) == 0)
						recv_steady = !recv_steady;
				end
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no accepted transfer of any kind
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(psel && penable && pwrite && pready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int                 directed_items;
		int                 phase;
		int                 n;
		int                 m;
		int                 count;
		int                 r;
		bit                 need_load;
		bit                 unsorted;
		logic [SCALE_W-1:0] scl;
		logic [KEY_W-1:0]   key_top;
		logic [KEY_W-1:0]   step;
		logic [63:0]        acc;
		logic [KEY_W-1:0]   key;
		sb = new();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_LOAD;
		s_tlast  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table after reset: nothing can be found
		draw_char(32'h0000_0000, 1'b0);
		draw_char(32'hFFFF_FFFF, 1'b1);
		drain();

		// four entries, smallest and largest keys and characters
		set_config(SCALE_ONE, 9'd4);
		load_entry(8'd0, 32'h0000_0000, 21'h000000);
		load_entry(8'd1, 32'h0000_0064, 21'h10FFFF);
		load_entry(8'd2, 32'hFFFF_FFFE, 21'h1FFFFF);
		load_entry(8'd3, 32'hFFFF_FFFF, 21'h0AAAAA);
		load_entry(8'd255, 32'hFFFF_FFFF, 21'h1FFFFF);
		draw_char(32'h0000_0000, 1'b0);
		draw_char(32'h0000_0063, 1'b1);
		draw_char(32'h0000_0064, 1'b0);
		draw_char(32'hFFFF_FFFD, 1'b1);
		// value saturates at the top
		draw_char(32'hFFFF_FFFF, 1'b0);
		drain();

		// zero scale leaves only the rounding offset
		set_config('0, 9'd4);
		draw_char($urandom(), 1'b1);
		drain();

		// largest scale saturates past the last key
		set_config(SCALE_MAX, 9'd3);
		draw_char(32'h0000_0000, 1'b0);
		draw_char(32'hFFFF_FFFF, 1'b1);
		drain();

		// single entry below every value
		set_config(SCALE_ONE, 9'd1);
		draw_char(32'h0000_0000, 1'b1);
		drain();
		directed_items = items_sent;

		// random phases: new registers, a fresh table, then mostly draws
		phase = 0;
		while (items_sent < directed_items + RANDOM_ITEMS) begin
			if (phase == 2) begin
				n = TABLE_DEPTH;
			end else if (phase == 5) begin
				n = ENTRIES_MAX;
			end else begin
				r = $urandom_range(0, 9);
				if (r == 0)
					n = 0;
				else if (r == 1)
					n = 1;
				else if (r == 2)
					n = 2;
				else
					n = $urandom_range(3, 24);
			end
			r = $urandom_range(0, 7);
			if (r == 0)
				scl = '0;
			else if (r == 1)
				scl = SCALE_MAX;
			else if (r <= 4)
				scl = SCALE_ONE;
			else if (r == 5)
				scl = {16'($urandom()), 32'($urandom())};
			else if (r == 6)
				scl = {16'h0, 32'($urandom())};
			else
				scl = {16'($urandom_range(0, 3)), 32'($urandom())};
			set_config(scl, TENT_W'(n));
			m = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;

			// keys spread over the reachable value range
			if (scl >= SCALE_ONE || scl[31:0] > 32'hFFFF_FFF0)
				key_top = 32'hFFFF_FFFF;
			else
				key_top = scl[31:0] + 32'd2;
			need_load = (m > 0 && m <= 32);
			for (int i = 0; i < m; i++)
				if (!loaded[i])
					need_load = 1'b1;
			if (need_load) begin
				unsorted = ($urandom_range(0, 5) == 0);
				step     = key_top / m;
				acc      = '0;
				for (int i = 0; i < m; i++) begin
					key = unsorted ? 32'($urandom_range(0, key_top)) : acc[31:0];
					acc = acc + 64'($urandom_range(0, step));
					load_entry(IDX_W'(i), key, CHAR_W'($urandom()));
				end
			end

			// draws with some aimed at stored keys, a few stray loads
			count = $urandom_range(15, 40);
			for (int k = 0; k < count; k++) begin
				r = $urandom_range(0, 19);
				if (r < 2)
					load_entry(IDX_W'($urandom()), $urandom(), CHAR_W'($urandom()));
				else if (r < 8 && m > 0 && scl == SCALE_ONE)
					draw_char(sb.thresholds[$urandom_range(0, m - 1)] - $urandom_range(0, 2),
						1'($urandom_range(0, 1)));
				else
					draw_char($urandom(), 1'($urandom_range(0, 1)));
			end
			drain();
			phase++;
		end

		sb.check_leftover();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
